[src/cnr_pkg.sv]
// ----------------------------------------------------------------------------
// cnr_pkg
// Shared constants and types for the compose-and-renumber map block.
// ----------------------------------------------------------------------------
package cnr_pkg;

  // Reduction table geometry.
  localparam int TABLE_DEPTH = 4096;
  localparam int INDEX_WIDTH = 12;
  localparam int TADDR_W     = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

  // The seen store covers every possible target value.
  localparam int SEEN_DEPTH  = 1 << INDEX_WIDTH;

  // Run tag kept beside each seen entry; tag zero never matches a live run.
  localparam int EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Stream widths.
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 2 * INDEX_WIDTH;
  localparam int OUT_USER_W  = 2;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPOSE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [EPOCH_W-1:0]     epoch;
    logic [INDEX_WIDTH-1:0] index;
  } seen_entry_t;

  localparam int SEEN_W = $bits(seen_entry_t);

  // Result flags as they travel on the master tuser, highest bit first.
  typedef struct packed {
    logic out_of_range;
    logic is_new;
  } out_flags_t;

endpackage

[src/cnr_ram.sv]
// ----------------------------------------------------------------------------
// cnr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/compose_and_renumber_map.sv]
// ----------------------------------------------------------------------------
// compose_and_renumber_map
// Composes a return map with a reduction map and renumbers targets densely.
// ----------------------------------------------------------------------------
// Load requests (tuser = 0) append one entry to the reduction table and
// leave the block idle; the first load after a load request marked with
// tlast starts a new table, and loads beyond the table depth are dropped.
// Compose requests (tuser = 1) pass through three steps: reading the
// reduction table, reading the seen store at the selected target, and
// writing the seen store back and registering the result. Only one compose
// request is in the datapath at a time, so the read of the seen store
// never overlaps a write to the same entry. A result waits in the output
// register while the next request is accepted; a compose request only
// stalls in its last step if that register is still full. The seen store
// is not cleared at the end of a run: each entry carries a run tag, and an
// entry counts as seen only when its tag matches the current run. After
// reset, and again after every 255th compose run when the tag wraps, the
// block sweeps all 4096 entries of the seen store back to tag zero and
// holds s_tready low meanwhile.
module compose_and_renumber_map (
  input  logic                            clk,
  input  logic                            rst,
  // Slave side.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cnr_pkg::IN_DATA_W-1:0]   s_tdata,  // [11:0] value, [15:12] zero
  input  logic [0:0]                      s_tuser,  // [0] command
  input  logic                            s_tlast,
  // Master side.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cnr_pkg::OUT_DATA_W-1:0]  m_tdata,  // [11:0] target_value,
                                                    // [23:12] induced_index
  output logic [cnr_pkg::OUT_USER_W-1:0]  m_tuser,  // [0] is_new, [1] out_of_range
  output logic                            m_tlast   // end_of_run
);

  import cnr_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SEEN
  } state_t;

  state_t                 state;
  logic [INDEX_WIDTH-1:0] clr_addr;
  logic [EPOCH_W-1:0]     epoch;
  logic [SIZE_W-1:0]      size;
  logic                   load_restart;
  logic [SIZE_W-1:0]      count;
  logic                   last_q;
  logic                   oor_q;
  logic [INDEX_WIDTH-1:0] target_q;

  // Request decode.
  logic                   s_accept;
  cmd_t                   cmd;
  logic [INDEX_WIDTH-1:0] s_val;
  logic [SIZE_W-1:0]      size_eff;
  logic                   table_room;
  logic [SIZE_W-1:0]      size_next;
  logic [SIZE_W-1:0]      count_next;

  // Memory ports.
  logic                   tbl_we;
  logic                   tbl_re;
  logic [INDEX_WIDTH-1:0] tbl_rdata;
  logic                   seen_we;
  logic                   seen_re;
  logic [INDEX_WIDTH-1:0] seen_waddr;
  seen_entry_t            seen_wdata;
  seen_entry_t            seen_rdata;

  // Result path.
  logic                   out_free;
  logic                   commit;
  logic                   seen_hit;
  logic                   is_new_w;
  logic [INDEX_WIDTH-1:0] induced_w;
  logic [INDEX_WIDTH-1:0] target_w;
  out_flags_t             flags_w;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser[0]);
  assign s_val    = s_tdata[INDEX_WIDTH-1:0];

  // A load after a finished load run writes from entry zero again.
  assign size_eff   = load_restart ? '0 : size;
  assign table_room = (size_eff < SIZE_W'(TABLE_DEPTH));
  assign size_next  = table_room ? size_eff + SIZE_W'(1) : size_eff;

  assign tbl_we = s_accept && (cmd == CMD_LOAD) && table_room;
  assign tbl_re = s_accept && (cmd == CMD_COMPOSE);

  cnr_ram #(
    .WIDTH (INDEX_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (size_eff[TADDR_W-1:0]),
    .wdata (s_val),
    .re    (tbl_re),
    .raddr (TADDR_W'(s_val)),
    .rdata (tbl_rdata)
  );

  // The seen store is read with the target straight out of the table read.
  assign seen_re  = (state == ST_LOOKUP);
  assign out_free = !m_tvalid || m_tready;
  assign commit   = (state == ST_SEEN) && out_free;
  assign seen_hit = (seen_rdata.epoch == epoch);
  assign is_new_w = !oor_q && !seen_hit;

  assign seen_we    = (state == ST_CLEAR) || (commit && is_new_w);
  assign seen_waddr = (state == ST_CLEAR) ? clr_addr : target_q;

  always_comb begin
    if (state == ST_CLEAR) begin
      seen_wdata = '0;
    end else begin
      seen_wdata.epoch = epoch;
      seen_wdata.index = count[INDEX_WIDTH-1:0];
    end
  end

  cnr_ram #(
    .WIDTH (SEEN_W),
    .DEPTH (SEEN_DEPTH)
  ) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (seen_re),
    .raddr (tbl_rdata),
    .rdata (seen_rdata)
  );

  // The distinct count saturates at the seen store depth.
  assign count_next = (count < SIZE_W'(SEEN_DEPTH)) ? count + SIZE_W'(1) : count;

  // Out-of-range elements report zero in every field but the flag.
  always_comb begin
    target_w  = '0;
    induced_w = '0;
    if (!oor_q) begin
      target_w  = target_q;
      induced_w = is_new_w ? count[INDEX_WIDTH-1:0] : seen_rdata.index;
    end
    flags_w.is_new       = is_new_w;
    flags_w.out_of_range = oor_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      epoch        <= EPOCH_FIRST;
      size         <= '0;
      load_restart <= 1'b1;
      count        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + INDEX_WIDTH'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_accept) begin
            if (cmd == CMD_LOAD) begin
              size         <= size_next;
              load_restart <= s_tlast;
            end else begin
              last_q <= s_tlast;
              oor_q  <= (SIZE_W'(s_val) >= size);
              state  <= ST_LOOKUP;
            end
          end
        end

        ST_LOOKUP: begin
          target_q <= tbl_rdata;
          state    <= ST_SEEN;
        end

        ST_SEEN: begin
          if (commit) begin
            m_tlast  <= last_q;
            m_tdata  <= {induced_w, target_w};
            m_tuser  <= flags_w;
            if (last_q) begin
              // Ending the run: move to a fresh tag, or sweep when it wraps.
              count <= '0;
              if (epoch == EPOCH_LAST) begin
                epoch    <= EPOCH_FIRST;
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end else begin
                epoch <= epoch + EPOCH_W'(1);
                state <= ST_IDLE;
              end
            end else begin
              if (is_new_w) begin
                count <= count_next;
              end
              state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

[src/cnr_checker.sv]
// ----------------------------------------------------------------------------
// cnr_checker
// Port-level checks for the compose-and-renumber map block.
// ----------------------------------------------------------------------------
module cnr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [cnr_pkg::IN_DATA_W-1:0]   s_tdata,
  input logic [0:0]                      s_tuser,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cnr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [cnr_pkg::OUT_USER_W-1:0]  m_tuser,
  input logic                            m_tlast
);

  import cnr_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // A load request taken with nothing pending yields no result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("load request produced a result");

  // A compose request occupies the datapath for the following cycle.
  a_compose_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == CMD_COMPOSE) |=> !s_tready)
    else $error("request accepted while a compose was in flight");

  // An out-of-range result carries zeros and is never new.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("out-of-range result with nonzero fields");

endmodule

bind compose_and_renumber_map cnr_checker u_cnr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/tb_compose_and_renumber_map.sv]
// ----------------------------------------------------------------------------
// tb_compose_and_renumber_map
// Self-checking bench for the compose-and-renumber map block. Load and
// compose requests go in through the slave stream. A bench-side copy of the
// reduction table and of the seen store predicts every compose result. Each
// result on the master stream is checked, field by field, against the oldest
// prediction. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb_compose_and_renumber_map;
  timeunit 1ns;
  timeprecision 1ps;
  import cnr_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_REQUESTS = 1750;
  localparam int SETTLE_CYCLES   = 16;
  localparam int REPORT_LIMIT    = 10;

  typedef logic [INDEX_WIDTH-1:0] idx_t;

  typedef struct packed {
    cmd_t cmd;
    idx_t value;
    logic last;
    logic wait_idle;  // hold this request until every result is back
  } request_t;

  typedef struct packed {
    idx_t target;
    logic is_new;
    idx_t index;
    logic out_of_range;
    logic end_of_run;
  } renumber_result_t;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata  = '0;  // [11:0] value, [15:12] zero
  logic [0:0]             s_tuser  = '0;  // [0] command
  logic                   s_tlast  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;        // [11:0] target_value, [23:12] induced_index
  logic [OUT_USER_W-1:0]  m_tuser;        // [0] is_new, [1] out_of_range
  logic                   m_tlast;        // end_of_run

  always #5 clk = ~clk;

  compose_and_renumber_map i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // Predictor: reduction table plus the per-run seen store and rank counter.
  // --------------------------------------------------------------------------
  idx_t             map_table   [TABLE_DEPTH];
  int unsigned      map_size    = 0;
  bit               map_restart = 1'b1;
  bit               target_seen [SEEN_DEPTH];
  idx_t             target_rank [SEEN_DEPTH];
  int unsigned      rank_count  = 0;
  renumber_result_t composed_results[$];

  function automatic void renumber_step(request_t r);
    renumber_result_t res;
    res = '0;
    if (r.cmd == CMD_LOAD) begin
      // A load after a marked last load starts a new table; a full table
      // drops further loads but still tracks the last mark.
      if (map_restart) map_size = 0;
      if (map_size < TABLE_DEPTH) begin
        map_table[map_size] = r.value;
        map_size++;
      end
      map_restart = r.last;
    end else begin
      res.end_of_run = r.last;
      if (r.value >= map_size) begin
        res.out_of_range = 1'b1;
      end else begin
        res.target = map_table[r.value];
        if (!target_seen[res.target]) begin
          target_seen[res.target] = 1'b1;
          target_rank[res.target] = idx_t'(rank_count);
          res.index  = idx_t'(rank_count);
          res.is_new = 1'b1;
          if (rank_count < SEEN_DEPTH) rank_count++;
        end else begin
          res.index = target_rank[res.target];
        end
      end
      composed_results.insert(composed_results.size(), res);
      if (r.last) begin
        target_seen = '{default: 1'b0};
        rank_count  = 0;
      end
    end
  endfunction

  // Wait in cycles before the next request or result; a steady stretch
  // turns the idling off for a while.
  function automatic int pick_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued requests and feeds the predictor on acceptance.
  // --------------------------------------------------------------------------
  request_t requests_to_send[$];
  request_t in_flight;
  int       send_gap    = 0;
  bit       send_steady = 1'b0;
  int       exp_total   = 0;
  int       got_total   = 0;
  logic     send_next;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      send_next = s_tvalid;
      if (s_tvalid && s_tready) begin
        renumber_step(in_flight);
        if (in_flight.cmd == CMD_COMPOSE) exp_total++;
        if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
        send_gap  = pick_wait(send_steady);
        send_next = 1'b0;
      end
      if (!send_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (requests_to_send.size() > 0 &&
                     (!requests_to_send[0].wait_idle || got_total == exp_total)) begin
          in_flight = requests_to_send.pop_front();
          s_tdata   <= IN_DATA_W'(in_flight.value);
          s_tuser   <= in_flight.cmd;
          s_tlast   <= in_flight.last;
          send_next = 1'b1;
        end
      end
      s_tvalid <= send_next;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction.
  // --------------------------------------------------------------------------
  int               mismatches  = 0;
  int               recv_stall  = 0;
  bit               recv_steady = 1'b0;
  renumber_result_t want;
  out_flags_t       flags;

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d: %s expected %0d, got %0d", got_total, name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        flags = m_tuser;
        got_total <= got_total + 1;
        if (composed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
        end else begin
          want = composed_results.pop_front();
          check_field("target_value", want.target, m_tdata[INDEX_WIDTH-1:0]);
          check_field("induced_index", want.index, m_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]);
          check_field("is_new", want.is_new, flags.is_new);
          check_field("out_of_range", want.out_of_range, flags.out_of_range);
          check_field("end_of_run", want.end_of_run, m_tlast);
        end
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        recv_stall = pick_wait(recv_steady);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus. The generator keeps its own table size so that most compose
  // elements land inside the loaded table.
  // --------------------------------------------------------------------------
  int unsigned gen_size    = 0;
  bit          gen_restart = 1'b1;

  function automatic void queue_request(cmd_t cmd, int unsigned value, bit last,
                                        bit wait_idle = 1'b0);
    request_t r;
    r.cmd       = cmd;
    r.value     = idx_t'(value);
    r.last      = last;
    r.wait_idle = wait_idle;
    requests_to_send.insert(requests_to_send.size(), r);
    if (cmd == CMD_LOAD) begin
      if (gen_restart) gen_size = 0;
      if (gen_size < TABLE_DEPTH) gen_size++;
      gen_restart = last;
    end
  endfunction

  // Mostly an element inside the table, sometimes any 12-bit value.
  function automatic int unsigned pick_element();
    if (gen_size == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, gen_size - 1);
  endfunction

  // Load values either spread wide or drawn from a small pool so that
  // different elements often select the same target.
  function automatic int unsigned pick_entry();
    return $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 7);
  endfunction

  int order [TABLE_DEPTH];
  int random_start, n_load, n_runs, n_comp, seq_no, swap_at, swap_val;

  initial begin
    // Compose on an empty table: every element is out of range.
    queue_request(CMD_COMPOSE, 0, 1'b0);
    queue_request(CMD_COMPOSE, 4095, 1'b1);

    // Small table with extreme entries and a repeated target.
    queue_request(CMD_LOAD, 12'hFFF, 1'b0);
    queue_request(CMD_LOAD, 12'h000, 1'b0);
    queue_request(CMD_LOAD, 12'hA5A, 1'b0);
    queue_request(CMD_LOAD, 12'h5A5, 1'b0);
    queue_request(CMD_LOAD, 12'hFFF, 1'b1);
    queue_request(CMD_COMPOSE, 0, 1'b0);
    queue_request(CMD_COMPOSE, 1, 1'b0);
    queue_request(CMD_COMPOSE, 4, 1'b0);   // same target as element 0
    queue_request(CMD_COMPOSE, 2, 1'b0);
    queue_request(CMD_COMPOSE, 3, 1'b0);
    queue_request(CMD_COMPOSE, 5, 1'b0);   // just past the table end
    queue_request(CMD_COMPOSE, 4095, 1'b1);

    // A load in the middle of a compose run replaces the table but keeps
    // the seen store of the run.
    queue_request(CMD_COMPOSE, 0, 1'b0);
    queue_request(CMD_LOAD, 12'hFFF, 1'b1);
    queue_request(CMD_COMPOSE, 0, 1'b0);
    queue_request(CMD_COMPOSE, 1, 1'b0);
    queue_request(CMD_COMPOSE, 0, 1'b1);

    // Full table: a load run past the depth, then one run over every
    // element so that the dense index climbs to its top value.
    for (int i = 0; i < TABLE_DEPTH + 4; i++)
      queue_request(CMD_LOAD, (i < TABLE_DEPTH) ? TABLE_DEPTH - 1 - i : pick_entry(),
                    i == TABLE_DEPTH + 3, i == 0);
    for (int i = 0; i < TABLE_DEPTH; i++) order[i] = i;
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      swap_at        = $urandom_range(0, i);
      swap_val       = order[i];
      order[i]       = order[swap_at];
      order[swap_at] = swap_val;
    end
    for (int i = 0; i < TABLE_DEPTH; i++)
      queue_request(CMD_COMPOSE, order[i], 1'b0, i == 0);
    queue_request(CMD_COMPOSE, $urandom_range(0, 4095), 1'b0);
    queue_request(CMD_COMPOSE, $urandom_range(0, 4095), 1'b1);

    // Random part: mostly well-formed load runs followed by short compose
    // runs, with bursts of arbitrary requests mixed in. Short runs make many
    // runs, so that the run tag can wrap.
    random_start = requests_to_send.size();
    seq_no       = 0;
    while (requests_to_send.size() < random_start + RANDOM_REQUESTS) begin
      seq_no++;
      if ($urandom_range(0, 9) < 7) begin
        n_load = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
        for (int i = 0; i < n_load; i++)
          queue_request(CMD_LOAD, pick_entry(), i == n_load - 1, i == 0 && seq_no % 20 == 0);
        n_runs = $urandom_range(1, 4);
        for (int k = 0; k < n_runs; k++) begin
          n_comp = $urandom_range(1, 6);
          for (int j = 0; j < n_comp; j++)
            queue_request(CMD_COMPOSE, pick_element(), j == n_comp - 1);
        end
      end else begin
        n_comp = $urandom_range(1, 6);
        for (int j = 0; j < n_comp; j++)
          queue_request(cmd_t'($urandom_range(0, 1)),
                        $urandom_range(0, 1) ? pick_element() : pick_entry(),
                        $urandom_range(0, 3) == 0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent and every predicted result returned.
    do @(negedge clk);
    while (requests_to_send.size() != 0 || s_tvalid || got_total != exp_total);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (composed_results.size() != 0)
      $display("%0d predicted results never arrived", composed_results.size());
    if (mismatches == 0 && composed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog against a stuck handshake.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
